FILE: design/pcefg_pkg.sv
package pcefg_pkg;

	localparam int APB_AW      = 4;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 72;

	// register index, paddr[3:2]
	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_WINDOW = 2'd1,
		REG_THRESH = 2'd2,
		REG_BLOCK  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_CHECK  = 1'b1
	} op_t;

	localparam logic        ENABLE_RST = 1'b1;
	localparam logic [15:0] WINDOW_RST = 16'd10;
	localparam logic [4:0]  THRESH_RST = 5'd5;
	localparam logic [15:0] BLOCK_RST  = 16'd60;

	typedef struct packed {
		logic [31:0] now;
		logic [15:0] member_mask;
		logic [3:0]  chan_index;
		logic        operation;
	} in_item_t;

	typedef struct packed {
		logic [31:0] flood_total;
		logic [31:0] suppressed_total;
		logic        block_extended;
		logic        flood_detected;
		logic        suppress_display;
	} out_item_t;

	// 33-bit add, saturating at all ones
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

FILE: design/per_channel_event_flood_guard_top.sv
// Channel  Dir  Width  Fields
// s_*      in   56     operation, chan_index, member_mask, now
// m_*      out  72     suppress_display, flood_detected, block_extended,
//                      suppressed_total, flood_total
// apb      in   32     enable, window_seconds, threshold, block_seconds
//
// One item in flight. A record reads its channel entry, reads stamps for expiry (up to
// RING_DEPTH, single read port of the stamp memory) and stores; on a blocked channel it only
// extends the block. A display check walks the channel table one entry a cycle, up to
// min(NUM_CHANNELS,16). Disabled skips all steps. s_tready rises with m_tvalid. Reset
// clears the channel table by its valid bits, no sweep; stamp memory is not cleared. A
// stalled result waits in the output register and the next item in the final step, s_tready low.
module per_channel_event_flood_guard_top
	import pcefg_pkg::*;
#(
	parameter int NUM_CHANNELS = 16,
	parameter int RING_DEPTH   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // operation, chan_index[3:0], member_mask[15:0], now[31:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // suppress_display, flood_detected, block_extended,
	                                         // suppressed_total[31:0], flood_total[31:0]
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int HEAD_W  = $clog2(RING_DEPTH);
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int SA_W    = $clog2(NUM_CHANNELS * RING_DEPTH);
	localparam int SCAN_N  = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
	localparam int SCAN_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
	localparam int META_W  = 32 + CNT_W + HEAD_W;
	localparam int NSTAMP  = NUM_CHANNELS * RING_DEPTH;

	typedef enum logic [2:0] {
		ST_IDLE, ST_META, ST_STAMP, ST_STORE, ST_SCAN, ST_FIN
	} state_t;

	function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
		return (h == HEAD_W'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	// configuration
	logic        enable_q;
	logic [15:0] window_q;
	logic [4:0]  thresh_q;
	logic [15:0] block_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			window_q <= WINDOW_RST;
			thresh_q <= THRESH_RST;
			block_q  <= BLOCK_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_WINDOW: window_q <= pwdata[15:0];
				REG_THRESH: thresh_q <= pwdata[4:0];
				REG_BLOCK:  block_q  <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ENABLE: prdata = {31'b0, enable_q};
			REG_WINDOW: prdata = {16'b0, window_q};
			REG_THRESH: prdata = {27'b0, thresh_q};
			REG_BLOCK:  prdata = {16'b0, block_q};
			default:    prdata = '0;
		endcase
	end

	// sequencer registers
	state_t            state_q;
	op_t               op_q;
	logic [CH_W-1:0]   chan_q;
	logic [15:0]       mask_q;
	logic [31:0]       now_q;
	logic [HEAD_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       end_q;
	logic [SCAN_W-1:0] scan_q;
	logic              res_zero_q, res_sup_q, res_flood_q, res_ext_q;
	logic [31:0]       sup_cnt_q, flood_cnt_q;
	logic              m_tvalid_q;
	out_item_t         out_q;

	in_item_t in_item;
	assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

	logic accept, in_range;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = {28'b0, in_item.chan_index} < 32'(NUM_CHANNELS);

	// channel table: block_end, event_count, ring_head
	logic [META_W-1:0]       meta_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] meta_vld_q;
	logic [META_W-1:0]       meta_rd_q;
	logic                    meta_rvld_q;
	logic                    meta_re, meta_we;
	logic [CH_W-1:0]         meta_raddr, meta_waddr;
	logic [META_W-1:0]       meta_wdata;

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_waddr] <= meta_wdata;
		if (meta_re)
			meta_rd_q <= meta_mem[meta_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q  <= '0;
			meta_rvld_q <= 1'b0;
		end else begin
			if (meta_we)
				meta_vld_q[meta_waddr] <= 1'b1;
			if (meta_re)
				meta_rvld_q <= meta_vld_q[meta_raddr];
		end
	end

	logic [31:0]       m_end;
	logic [CNT_W-1:0]  m_cnt;
	logic [HEAD_W-1:0] m_head;
	assign {m_end, m_cnt, m_head} = meta_rvld_q ? meta_rd_q : '0;

	// event stamp rings
	logic [31:0]     stamp_mem [NSTAMP];
	logic [31:0]     stamp_rd_q;
	logic            stamp_re, stamp_we;
	logic [SA_W-1:0] stamp_raddr, stamp_waddr;

	always_ff @(posedge clk) begin
		if (stamp_we)
			stamp_mem[stamp_waddr] <= now_q;
		if (stamp_re)
			stamp_rd_q <= stamp_mem[stamp_raddr];
	end

	// datapath
	logic [SA_W-1:0]   base;
	logic [31:0]       new_end;
	logic              blocked, stale, hit;
	logic              st_drop, st_flood;
	logic [HEAD_W-1:0] st_head, st_slot;
	logic [CNT_W-1:0]  st_cnt, st_cnt_new;
	logic [CNT_W:0]    st_sum;
	logic [15:0]       mask_sh;
	logic [CH_W-1:0]   scan_ch;

	assign base     = SA_W'(chan_q) * SA_W'(RING_DEPTH);
	assign new_end  = sat_add(now_q, block_q);
	assign blocked  = now_q < m_end;
	assign stale    = ({1'b0, stamp_rd_q} + {17'b0, window_q}) < {1'b0, now_q};
	assign mask_sh  = mask_q >> scan_q;
	assign hit      = mask_sh[0] && blocked;
	assign scan_ch  = CH_W'(scan_q);

	assign st_drop    = (cnt_q == CNT_W'(RING_DEPTH));
	assign st_head    = st_drop ? head_inc(head_q) : head_q;
	assign st_cnt     = st_drop ? cnt_q - 1'b1 : cnt_q;
	assign st_sum     = (CNT_W+1)'(st_head) + (CNT_W+1)'(st_cnt);
	assign st_slot    = (st_sum >= (CNT_W+1)'(RING_DEPTH))
	                    ? HEAD_W'(st_sum - (CNT_W+1)'(RING_DEPTH)) : HEAD_W'(st_sum);
	assign st_cnt_new = st_cnt + 1'b1;
	assign st_flood   = 32'(st_cnt_new) >= 32'(thresh_q);

	always_comb begin
		meta_re     = 1'b0;
		meta_raddr  = chan_q;
		meta_we     = 1'b0;
		meta_waddr  = chan_q;
		meta_wdata  = {new_end, m_cnt, m_head};
		stamp_re    = 1'b0;
		stamp_raddr = base + SA_W'(m_head);
		stamp_we    = 1'b0;
		stamp_waddr = base + SA_W'(st_slot);
		case (state_q)
			ST_IDLE: begin
				if (accept && enable_q) begin
					meta_re    = (in_item.operation == OP_CHECK) || in_range;
					meta_raddr = (in_item.operation == OP_CHECK) ? '0
					             : CH_W'(in_item.chan_index);
				end
			end
			ST_META: begin
				if (blocked)
					meta_we = 1'b1;
				else
					stamp_re = (m_cnt != '0);
			end
			ST_STAMP: begin
				stamp_re    = stale && (cnt_q != CNT_W'(1));
				stamp_raddr = base + SA_W'(head_inc(head_q));
			end
			ST_STORE: begin
				stamp_we   = 1'b1;
				meta_we    = 1'b1;
				meta_wdata = {st_flood ? new_end : end_q, st_cnt_new, st_head};
			end
			ST_SCAN: begin
				meta_re    = (scan_q != SCAN_W'(SCAN_N - 1));
				meta_raddr = CH_W'(scan_q + 1'b1);
				meta_we    = hit;
				meta_waddr = scan_ch;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_RECORD;
			chan_q      <= '0;
			mask_q      <= '0;
			now_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			end_q       <= '0;
			scan_q      <= '0;
			res_zero_q  <= 1'b0;
			res_sup_q   <= 1'b0;
			res_flood_q <= 1'b0;
			res_ext_q   <= 1'b0;
			sup_cnt_q   <= '0;
			flood_cnt_q <= '0;
			m_tvalid_q  <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == ST_FIN && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= op_t'(in_item.operation);
						chan_q      <= CH_W'(in_item.chan_index);
						mask_q      <= in_item.member_mask;
						now_q       <= in_item.now;
						scan_q      <= '0;
						res_zero_q  <= !enable_q;
						res_sup_q   <= 1'b0;
						res_flood_q <= 1'b0;
						res_ext_q   <= 1'b0;
						if (!enable_q)
							state_q <= ST_FIN;
						else if (in_item.operation == OP_CHECK)
							state_q <= ST_SCAN;
						else if (in_range)
							state_q <= ST_META;
						else
							state_q <= ST_FIN;
					end
				end
				ST_META: begin
					head_q <= m_head;
					cnt_q  <= m_cnt;
					end_q  <= m_end;
					if (blocked) begin
						res_ext_q <= 1'b1;
						state_q   <= ST_FIN;
					end else if (m_cnt != '0) begin
						state_q <= ST_STAMP;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_STAMP: begin
					if (stale) begin
						head_q <= head_inc(head_q);
						cnt_q  <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1))
							state_q <= ST_STORE;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (st_flood) begin
						flood_cnt_q <= flood_cnt_q + 1'b1;
						res_flood_q <= 1'b1;
						res_ext_q   <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					if (hit) begin
						sup_cnt_q <= sup_cnt_q + 1'b1;
						res_sup_q <= 1'b1;
						res_ext_q <= 1'b1;
						state_q   <= ST_FIN;
					end else if (scan_q == SCAN_W'(SCAN_N - 1)) begin
						state_q <= ST_FIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						out_q.suppress_display <= res_sup_q;
						out_q.flood_detected   <= res_flood_q;
						out_q.block_extended   <= res_ext_q;
						out_q.suppressed_total <= res_zero_q ? '0 : sup_cnt_q;
						out_q.flood_total      <= res_zero_q ? '0 : flood_cnt_q;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - $bits(out_item_t))'(0), out_q};

	// a flood always rewrites the block end
	a_flood_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] || m_tdata[2]))
		else $error("flood without block extension");

	// flood total only moves on the store step of a record
	a_flood_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(flood_cnt_q != $past(flood_cnt_q)) |-> $past(state_q == ST_STORE))
		else $error("flood counter moved outside store");

	// no memory writes while waiting for a new transfer
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!meta_we && !stamp_we))
		else $error("memory write while idle");

	// a check never touches the stamp rings
	a_scan_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!stamp_re && !stamp_we && op_q == OP_CHECK))
		else $error("stamp access during display check");

endmodule

FILE: tb/sv/tb.sv
module tb;
	import pcefg_pkg::*;

	localparam int CHANS          = 16;
	localparam int RING           = 16;
	localparam int SETTLE_CYCLES  = 32;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // operation, chan_index, member_mask, now
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;       // suppress_display, flood_detected, block_extended,
	                                       // suppressed_total, flood_total
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	per_channel_event_flood_guard_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the configuration and channel state
	logic        cfg_enable = ENABLE_RST;
	logic [15:0] cfg_window = WINDOW_RST;
	logic [4:0]  cfg_thresh = THRESH_RST;
	logic [15:0] cfg_block  = BLOCK_RST;

	logic [31:0] ev_stamps [CHANS][RING];
	logic [3:0]  ev_head   [CHANS] = '{default: '0};
	logic [4:0]  ev_count  [CHANS] = '{default: '0};
	logic [31:0] blk_end   [CHANS] = '{default: '0};
	logic [31:0] supp_total  = '0;
	logic [31:0] flood_count = '0;

	in_item_t  pending_items[$];
	out_item_t expected_results[$];

	int          mismatch_count = 0;
	int          results_seen = 0;
	int          send_gap = 0;
	int          send_calm = 0;
	int          recv_wait = 0;
	int          recv_calm = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [31:0] clock_now = '0;

	function automatic logic [31:0] block_until(logic [31:0] t);
		logic [32:0] sum;
		sum = {1'b0, t} + {17'b0, cfg_block};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic out_item_t guard_predict(in_item_t it);
		out_item_t  r;
		logic [3:0] c;
		logic [3:0] slot;
		r = '0;
		if (!cfg_enable)
			return r;
		if (it.operation == OP_RECORD) begin
			c = it.chan_index;
			if (it.now < blk_end[c]) begin
				blk_end[c] = block_until(it.now);
				r.block_extended = 1'b1;
			end else begin
				// drop stale stamps oldest first, stop at the first fresh one
				while (ev_count[c] != 0 &&
				       ({1'b0, ev_stamps[c][ev_head[c]]} + {17'b0, cfg_window}) < {1'b0, it.now}) begin
					ev_head[c]++;
					ev_count[c]--;
				end
				if (ev_count[c] == RING) begin
					ev_head[c]++;
					ev_count[c]--;
				end
				slot = ev_head[c] + ev_count[c][3:0];
				ev_stamps[c][slot] = it.now;
				ev_count[c]++;
				if (ev_count[c] >= cfg_thresh) begin
					blk_end[c] = block_until(it.now);
					flood_count++;
					r.flood_detected = 1'b1;
					r.block_extended = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < CHANS; i++) begin
				if (it.member_mask[i] && it.now < blk_end[i]) begin
					blk_end[i] = block_until(it.now);
					supp_total++;
					r.suppress_display = 1'b1;
					r.block_extended = 1'b1;
					break;
				end
			end
		end
		r.suppressed_total = supp_total;
		r.flood_total = flood_count;
		return r;
	endfunction

	task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(guard_predict(in_item_t'(s_tdata[$bits(in_item_t)-1:0])));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					s_tdata <= IN_TDATA_W'(pending_items.pop_front());
					s_tvalid <= 1'b1;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						send_gap = $urandom_range(0, 6);
						if ($urandom_range(0, 24) == 0)
							send_calm = $urandom_range(10, 40);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_item_t got;
				out_item_t want;
				got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: actual %0h", $time, got);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("suppress_display", 32'(want.suppress_display),
					            32'(got.suppress_display));
					check_field("flood_detected", 32'(want.flood_detected),
					            32'(got.flood_detected));
					check_field("block_extended", 32'(want.block_extended),
					            32'(got.block_extended));
					check_field("suppressed_total", want.suppressed_total, got.suppressed_total);
					check_field("flood_total", want.flood_total, got.flood_total);
				end
				results_seen++;
				if (recv_calm > 0) begin
					recv_calm--;
					recv_wait = 0;
				end else begin
					recv_wait = $urandom_range(0, 6);
					if ($urandom_range(0, 24) == 0)
						recv_calm = $urandom_range(10, 40);
				end
				// long back-pressure so the block fills and stalls its input
				if (results_seen == 300 || results_seen == 900)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ENABLE: cfg_enable = val[0];
			REG_WINDOW: cfg_window = val[15:0];
			REG_THRESH: cfg_thresh = val[4:0];
			REG_BLOCK:  cfg_block  = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic en, logic [15:0] win, logic [4:0] thr, logic [15:0] blk);
		write_reg(REG_ENABLE, {31'b0, en});
		write_reg(REG_WINDOW, {16'b0, win});
		write_reg(REG_THRESH, {27'b0, thr});
		write_reg(REG_BLOCK, {16'b0, blk});
		@(negedge clk);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// unused fields get random content
	task automatic push_item(op_t op, logic [3:0] ch, logic [15:0] mask, logic [31:0] t);
		in_item_t it;
		it.operation = op;
		it.chan_index = (op == OP_RECORD) ? ch : 4'($urandom);
		it.member_mask = (op == OP_CHECK) ? mask : 16'($urandom);
		it.now = t;
		pending_items.push_back(it);
	endtask

	function automatic in_item_t rand_item();
		in_item_t    it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			clock_now += $urandom_range(0, 2);
		else if (r < 88)
			clock_now += $urandom_range(3, 20);
		else if (r < 97)
			clock_now += $urandom_range(21, 300);
		else if (r < 99)
			clock_now = $urandom;  // arbitrary jump, forward or backward
		else
			clock_now = 32'hFFFF_FFFF - $urandom_range(0, 400);
		it.now = clock_now;
		it.operation = ($urandom_range(0, 9) < 7) ? OP_RECORD : OP_CHECK;
		// a few hot channels so floods and blocks actually happen
		it.chan_index = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
		                                            : 4'($urandom_range(0, 15));
		r = $urandom_range(0, 9);
		if (r < 4)
			it.member_mask = 16'h1 << $urandom_range(0, 3);
		else if (r < 6)
			it.member_mask = 16'h1 << $urandom_range(0, 15);
		else if (r < 8)
			it.member_mask = 16'($urandom);
		else if (r == 8)
			it.member_mask = 16'hFFFF;
		else
			it.member_mask = 16'h0000;
		return it;
	endfunction

	task automatic random_phase(logic en, logic [15:0] win, logic [4:0] thr, logic [15:0] blk,
	                            int count, logic [31:0] start);
		set_config(en, win, thr, blk);
		clock_now = start;
		repeat (count) pending_items.push_back(rand_item());
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, nothing expires while now is below the window
		set_config(ENABLE_RST, WINDOW_RST, THRESH_RST, BLOCK_RST);
		push_item(OP_CHECK, 4'd0, 16'hFFFF, 32'd0);
		repeat (5) push_item(OP_RECORD, 4'd0, 16'h0, 32'd0);
		push_item(OP_RECORD, 4'd0, 16'h0, 32'd1);        // blocked: extend only
		push_item(OP_CHECK, 4'd0, 16'h0001, 32'd2);      // suppress
		push_item(OP_RECORD, 4'd0, 16'h0, 32'd62);       // block just over, all stamps stale
		push_item(OP_CHECK, 4'd0, 16'h8000, 32'd300);
		drain();

		// block end saturates near the top of time
		set_config(1'b1, 16'hFFFF, 5'd1, 16'hFFFF);
		push_item(OP_RECORD, 4'd7, 16'h0, 32'hFFFF_FFF0);
		push_item(OP_CHECK, 4'd0, 16'h0080, 32'hFFFF_FFF8);
		push_item(OP_RECORD, 4'd7, 16'h0, 32'hFFFF_FFFF);
		push_item(OP_CHECK, 4'd0, 16'h0000, 32'hFFFF_FFFF);
		drain();

		// zero block time never blocks, so the ring fills and saturates
		set_config(1'b1, 16'hFFFF, 5'd16, 16'd0);
		repeat (17) push_item(OP_RECORD, 4'd3, 16'h0, 32'd5);
		drain();

		random_phase(1'b1, WINDOW_RST, THRESH_RST, BLOCK_RST, 250, 32'd0);
		random_phase(1'b1, 16'd0, 5'd1, 16'd0, 150, 32'd3);
		random_phase(1'b1, 16'hFFFF, 5'd16, 16'hFFFF, 150, 32'd0);
		random_phase(1'b0, 16'd20, 5'd3, 16'd30, 50, 32'd100);
		for (int k = 0; k < 5; k++) begin
			if (k == 4)
				random_phase(1'b1, 16'($urandom), 5'($urandom_range(1, 16)), 16'($urandom),
				             150, $urandom);
			else
				random_phase(1'b1, 16'($urandom_range(0, 60)), 5'($urandom_range(1, 16)),
				             16'($urandom_range(0, 100)), 150, 32'($urandom_range(0, 30)));
		end

		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
